[src/asas_pkg.sv]
// ----------------------------------------------------------------------------
// asas_pkg
// shared types and constants for the affine sprite additive splat block
// ----------------------------------------------------------------------------
package asas_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_FRAME  = 2'd0,
        OP_WRITE_SPRITE = 2'd1,
        OP_READ_FRAME   = 2'd2,
        OP_SPLAT        = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_START_U  = 3'd0,
        REG_START_V  = 3'd1,
        REG_COL_U    = 3'd2,
        REG_COL_V    = 3'd3,
        REG_ROW_U    = 3'd4,
        REG_ROW_V    = 3'd5,
        REG_BOX_SIZE = 3'd6
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_OUT
    } t_state;

    localparam int CHAN_W = 16;
    localparam int PIX_W  = 48;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_pix;

    // one pixel step of the walk, issued to the pixel pipeline
    typedef struct packed {
        logic        valid;
        logic [15:0] frame_addr;
        logic [15:0] sprite_addr;
    } t_req;

endpackage

[src/asas_pixel_pipe.sv]
// ----------------------------------------------------------------------------
// asas_pixel_pipe
// frame and sprite memories with a read, multiply, add and write back pipeline
// ----------------------------------------------------------------------------
module asas_pixel_pipe #(
    parameter int FRAME_AW  = 16,
    parameter int SPRITE_AW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fwr,
    input  logic [FRAME_AW-1:0]  i_faddr,
    input  asas_pkg::t_pix       i_fdata,
    input  logic                 i_swr,
    input  logic [SPRITE_AW-1:0] i_saddr,
    input  asas_pkg::t_pix       i_sdata,
    input  asas_pkg::t_req       i_req,
    input  asas_pkg::t_pix       i_tint,
    output asas_pkg::t_pix       o_rdata,
    output logic                 o_busy,
    output logic                 o_sat
);
    logic [asas_pkg::PIX_W-1:0] frame_mem [2**FRAME_AW];
    logic [asas_pkg::PIX_W-1:0] sprite_mem [2**SPRITE_AW];

    // stage 1: memory read
    logic                 r_v1;
    logic [FRAME_AW-1:0]  r_fa1;
    asas_pkg::t_pix       r_fd1, r_sd1;
    // stage 2: products
    logic                 r_v2;
    logic [FRAME_AW-1:0]  r_fa2;
    asas_pkg::t_pix       r_fd2;
    logic [31:0]          r_pr, r_pg, r_pb;
    // stage 3 writes back
    logic [16:0]          sr, sg, sb;
    asas_pkg::t_pix       wb;

    always_ff @(posedge i_clk) begin
        if (i_fwr) frame_mem[i_faddr] <= i_fdata;
        else if (r_v2) frame_mem[r_fa2] <= wb;
        if (i_swr) sprite_mem[i_saddr] <= i_sdata;
        r_fd1 <= frame_mem[i_req.valid ? i_req.frame_addr[FRAME_AW-1:0] : i_faddr];
        r_sd1 <= sprite_mem[i_req.sprite_addr[SPRITE_AW-1:0]];
        r_fa1 <= i_req.frame_addr[FRAME_AW-1:0];
        r_fa2 <= r_fa1;
        r_fd2 <= r_fd1;
        r_pr  <= 32'(r_sd1.r) * 32'(i_tint.r);
        r_pg  <= 32'(r_sd1.g) * 32'(i_tint.g);
        r_pb  <= 32'(r_sd1.b) * 32'(i_tint.b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        sr = 17'(r_fd2.r) + 17'(r_pr[27:12]);
        sg = 17'(r_fd2.g) + 17'(r_pg[27:12]);
        sb = 17'(r_fd2.b) + 17'(r_pb[27:12]);
        // products above 16 bits after the shift always saturate
        wb.r = (sr[16] || r_pr[31:28] != 4'd0) ? 16'hFFFF : sr[15:0];
        wb.g = (sg[16] || r_pg[31:28] != 4'd0) ? 16'hFFFF : sg[15:0];
        wb.b = (sb[16] || r_pb[31:28] != 4'd0) ? 16'hFFFF : sb[15:0];
        o_sat = r_v2 && (wb.r == 16'hFFFF && (sr[16] || r_pr[31:28] != 4'd0)
                      || wb.g == 16'hFFFF && (sg[16] || r_pg[31:28] != 4'd0)
                      || wb.b == 16'hFFFF && (sb[16] || r_pb[31:28] != 4'd0));
        o_busy  = r_v1 || r_v2;
        o_rdata = r_fd1;
    end
endmodule

[src/asas_walker.sv]
// ----------------------------------------------------------------------------
// asas_walker
// box walker: steps sprite coordinates and issues at most one pixel per cycle
// ----------------------------------------------------------------------------
module asas_walker #(
    parameter int FRAME_WIDTH   = 256,
    parameter int FRAME_HEIGHT  = 256,
    parameter int SPRITE_WIDTH  = 64,
    parameter int SPRITE_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [10:0] i_x0,
    input  logic signed [10:0] i_y0,
    input  logic [31:0]        i_su,
    input  logic [31:0]        i_sv,
    input  logic [31:0]        i_cu,
    input  logic [31:0]        i_cv,
    input  logic [31:0]        i_ru,
    input  logic [31:0]        i_rv,
    input  logic [6:0]         i_box,
    output asas_pkg::t_req     o_req,
    output logic               o_done
);
    localparam logic [31:0] ULIM = 32'(SPRITE_WIDTH - 1) << 16;
    localparam logic [31:0] VLIM = 32'(SPRITE_HEIGHT - 1) << 16;

    logic               r_act, n_act;
    logic [7:0]         r_col, n_col, r_row, n_row;
    logic [31:0]        r_cu, n_cu, r_cv, n_cv, r_wu, n_wu, r_wv, n_wv;
    logic signed [10:0] r_x0, r_y0;
    logic [7:0]         span;
    logic signed [11:0] x, y;
    logic               hit;
    logic [31:0]        fi, si;

    always_comb begin
        span = {i_box, 1'b0};
        x = 12'(r_x0) + $signed({4'd0, r_col});
        y = 12'(r_y0) + $signed({4'd0, r_row});
        hit = r_act && x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT
            && r_wu < ULIM && r_wv < VLIM;
        fi = 32'(y[10:0]) * 32'(FRAME_WIDTH) + 32'(x[10:0]);
        si = 32'(r_wv[31:16]) * 32'(SPRITE_WIDTH) + 32'(r_wu[31:16]);
        o_req.valid       = hit;
        o_req.frame_addr  = fi[15:0];
        o_req.sprite_addr = si[15:0];
        n_act = r_act; n_col = r_col; n_row = r_row;
        n_cu = r_cu; n_cv = r_cv; n_wu = r_wu; n_wv = r_wv;
        o_done = 1'b0;
        if (i_start) begin
            n_act = span != 8'd0;
            o_done = span == 8'd0;
            n_col = 8'd0; n_row = 8'd0;
            n_cu = i_su; n_cv = i_sv; n_wu = i_su; n_wv = i_sv;
        end else if (r_act) begin
            // whole column skipped when outside the frame
            if (r_row == span - 8'd1 || x < 0 || x >= FRAME_WIDTH) begin
                n_row = 8'd0;
                n_col = r_col + 8'd1;
                n_cu = r_cu + i_cu; n_cv = r_cv + i_cv;
                n_wu = n_cu; n_wv = n_cv;
                if (r_col == span - 8'd1) begin
                    n_act = 1'b0;
                    o_done = 1'b1;
                end
            end else begin
                n_row = r_row + 8'd1;
                n_wu = r_wu + i_ru; n_wv = r_wv + i_rv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_col <= '0;
            r_row <= '0;
            r_cu <= '0; r_cv <= '0; r_wu <= '0; r_wv <= '0;
        end else begin
            r_act <= n_act;
            r_col <= n_col; r_row <= n_row;
            r_cu <= n_cu; r_cv <= n_cv; r_wu <= n_wu; r_wv <= n_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x0 <= i_x0;
            r_y0 <= i_y0;
        end
    end
endmodule

[src/affine_sprite_additive_splat_top.sv]
// ----------------------------------------------------------------------------
// affine_sprite_additive_splat_top
// frame and sprite stores with an affine additive sprite splat
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in       input      i_valid / o_stall
// out      output     o_valid / i_stall
// cfg      input      i_cfg_wr, plain write
// a write answers through the result register, a read after the memory read stage;
// a splat is walked by the walker, which issues at most one pixel a cycle into the
// memory pipeline and skips columns outside the frame. reset is synchronous, active
// low; the stores are not cleared. the result register holds under i_stall.
// ----------------------------------------------------------------------------
module affine_sprite_additive_splat_top #(
    parameter int FRAME_WIDTH   = 256,
    parameter int FRAME_HEIGHT  = 256,
    parameter int SPRITE_WIDTH  = 64,
    parameter int SPRITE_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [15:0] i_red,
    input  logic [15:0] i_green,
    input  logic [15:0] i_blue,
    input  logic signed [10:0] i_box_x0,
    input  logic signed [10:0] i_box_y0,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_red,
    output logic [15:0] o_read_green,
    output logic [15:0] o_read_blue,
    output logic        o_saturated,
    input  logic        i_cfg_wr,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int FPIX = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int SPIX = SPRITE_WIDTH * SPRITE_HEIGHT;
    localparam int FAW  = $clog2(FPIX);
    localparam int SAW  = $clog2(SPIX);

    asas_pkg::t_state r_state, n_state;
    logic [31:0] r_su, r_sv, r_cu, r_cv, r_ru, r_rv;
    logic [6:0]  r_box;
    asas_pkg::t_pix r_tint, rdata;
    logic        r_sat, n_sat, r_rd_ok;
    asas_pkg::t_req req;
    logic        busy, psat, wdone, start, acc, fwr, swr;
    asas_pkg::t_pix r_out_pix, n_out_pix;
    logic        r_out_sat, n_out_sat;
    asas_pkg::t_op op;

    assign op  = asas_pkg::t_op'(i_operation);
    assign acc = i_valid && !o_stall;
    assign fwr = acc && op == asas_pkg::OP_WRITE_FRAME && 32'(i_address) < FPIX;
    assign swr = acc && op == asas_pkg::OP_WRITE_SPRITE && 32'(i_address) < SPIX;
    assign start = acc && op == asas_pkg::OP_SPLAT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su <= '0; r_sv <= '0; r_cu <= '0; r_cv <= '0;
            r_ru <= '0; r_rv <= '0; r_box <= '0;
        end else if (i_cfg_wr) begin
            case (asas_pkg::t_reg'(i_cfg_index))
                asas_pkg::REG_START_U:  r_su <= i_cfg_data;
                asas_pkg::REG_START_V:  r_sv <= i_cfg_data;
                asas_pkg::REG_COL_U:    r_cu <= i_cfg_data;
                asas_pkg::REG_COL_V:    r_cv <= i_cfg_data;
                asas_pkg::REG_ROW_U:    r_ru <= i_cfg_data;
                asas_pkg::REG_ROW_V:    r_rv <= i_cfg_data;
                asas_pkg::REG_BOX_SIZE: r_box <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) r_tint <= {i_red, i_green, i_blue};
        if (acc) r_rd_ok <= 32'(i_address) < FPIX;
    end

    asas_walker #(
        .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT),
        .SPRITE_WIDTH(SPRITE_WIDTH), .SPRITE_HEIGHT(SPRITE_HEIGHT)
    ) u_walker (
        .i_clk, .i_rst_n, .i_start(start), .i_x0(i_box_x0), .i_y0(i_box_y0),
        .i_su(r_su), .i_sv(r_sv), .i_cu(r_cu), .i_cv(r_cv), .i_ru(r_ru),
        .i_rv(r_rv), .i_box(r_box), .o_req(req), .o_done(wdone)
    );

    asas_pixel_pipe #(.FRAME_AW(FAW), .SPRITE_AW(SAW)) u_pipe (
        .i_clk, .i_rst_n,
        .i_fwr(fwr), .i_faddr(i_address[FAW-1:0]), .i_fdata({i_red, i_green, i_blue}),
        .i_swr(swr), .i_saddr(i_address[SAW-1:0]), .i_sdata({i_red, i_green, i_blue}),
        .i_req(req), .i_tint(r_tint), .o_rdata(rdata), .o_busy(busy), .o_sat(psat)
    );

    always_comb begin
        n_state = r_state;
        n_sat = r_sat;
        n_out_pix = r_out_pix;
        n_out_sat = r_out_sat;
        o_stall = 1'b1;
        if (o_valid && !i_stall) n_out_pix = '0;
        case (r_state)
            asas_pkg::ST_IDLE: begin
                o_stall = o_valid && i_stall;
                if (acc) begin
                    n_sat = 1'b0;
                    case (op)
                        asas_pkg::OP_READ_FRAME: n_state = asas_pkg::ST_READ;
                        // empty box has nothing to walk
                        asas_pkg::OP_SPLAT: n_state = (r_box == 7'd0) ? asas_pkg::ST_OUT
                                                                       : asas_pkg::ST_WALK;
                        default: begin
                            n_out_pix = '0;
                            n_out_sat = 1'b0;
                        end
                    endcase
                end
            end
            asas_pkg::ST_READ: begin
                n_out_pix = r_rd_ok ? rdata : '0;
                n_out_sat = 1'b0;
                n_state = asas_pkg::ST_IDLE;
            end
            asas_pkg::ST_WALK: begin
                n_sat = r_sat || psat;
                if (wdone) n_state = asas_pkg::ST_OUT;
            end
            asas_pkg::ST_OUT: begin
                n_sat = r_sat || psat;
                if (!busy && !psat) begin
                    n_out_pix = '0;
                    n_out_sat = n_sat;
                    n_state = asas_pkg::ST_IDLE;
                end
            end
            default: n_state = asas_pkg::ST_IDLE;
        endcase
    end

    logic r_ov, n_ov;
    always_comb begin
        n_ov = o_valid && i_stall;
        if (r_state == asas_pkg::ST_IDLE && acc && op != asas_pkg::OP_READ_FRAME
            && op != asas_pkg::OP_SPLAT) n_ov = 1'b1;
        if (r_state == asas_pkg::ST_READ) n_ov = 1'b1;
        if (r_state == asas_pkg::ST_OUT && !busy && !psat) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asas_pkg::ST_IDLE;
            r_sat <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sat <= n_sat;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pix <= n_out_pix;
        r_out_sat <= n_out_sat;
    end

    assign o_valid      = r_ov;
    assign o_read_red   = r_out_pix.r;
    assign o_read_green = r_out_pix.g;
    assign o_read_blue  = r_out_pix.b;
    assign o_saturated  = r_out_sat;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != asas_pkg::ST_IDLE |-> o_stall)
        else $error("item accepted while busy");
    a_walk_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid |-> r_state == asas_pkg::ST_WALK)
        else $error("pixel issued outside splat");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_saturated))
        else $error("stalled result changed");
endmodule
